>>> rtl/lda_gibbs_topic_resampler_assert.svh
// ---------------------------------------------------------------------------
// LDA Gibbs topic resampler assertion macros
// Clocked, reset-gated property shorthands used by the controller.
// ---------------------------------------------------------------------------
`ifndef LDA_GIBBS_TOPIC_RESAMPLER_ASSERT_SVH
`define LDA_GIBBS_TOPIC_RESAMPLER_ASSERT_SVH
// same-cycle implication
`define LGTR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define LGTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/lgtr_pkg.sv
// ---------------------------------------------------------------------------
// LDA Gibbs topic resampler package
// Sizes, item types, codes and controller/datapath interface structs.
// ---------------------------------------------------------------------------
package lgtr_pkg;

  localparam int MAX_TOPICS  = 64;
  localparam int MAX_VOCAB   = 4096;
  localparam int MAX_DOCS    = 1024;
  localparam int COUNT_WIDTH = 16;
  localparam int TOTAL_WIDTH = COUNT_WIDTH + 8;
  localparam int TOPIC_W     = 6;
  localparam int DOC_W       = 10;
  localparam int WORD_W      = 12;
  localparam int KN_W        = 7;
  localparam int VN_W        = 13;
  localparam int WEIGHT_W    = 48;
  localparam int OPER_W      = COUNT_WIDTH + 13;
  localparam int PROD_W      = 2 * OPER_W;
  localparam int BV_W        = 16 + VN_W;
  localparam int DEN_W       = TOTAL_WIDTH + 13;
  localparam int DOC_AW      = DOC_W + TOPIC_W;
  localparam int WORD_AW     = WORD_W + TOPIC_W;
  localparam int DIV_CW      = 6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_COUNT = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] REG_ALPHA = 2'd0;
  localparam logic [1:0] REG_BETA  = 2'd1;
  localparam logic [1:0] REG_TOPIC = 2'd2;
  localparam logic [1:0] REG_VOCAB = 2'd3;

  typedef struct packed {
    logic                opcode;
    logic [DOC_W-1:0]    doc_index;
    logic [WORD_W-1:0]   word_id;
    logic [TOPIC_W-1:0]  current_topic;
    logic [15:0]         random_fraction;
  } item_t;

  typedef struct packed {
    logic [TOPIC_W-1:0] new_topic;
    logic [1:0]         status;
  } result_t;

  typedef struct packed {
    logic [15:0]     alpha;
    logic [15:0]     beta;
    logic [KN_W-1:0] topics;
    logic [VN_W-1:0] vocab;
  } cfg_t;

  typedef enum logic [1:0] {SEL_CUR, SEL_K, SEL_PICK} sel_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ORD, S_OUPD, S_KRD, S_KMUL, S_DSTART, S_DWAIT,
    S_ACC, S_TGT, S_SRD, S_SCMP, S_ARD, S_AUPD, S_EMIT
  } state_t;

  typedef struct packed {
    logic clr;
    logic latch;
    sel_t sel;
    logic upd;
    logic upd_add;
    logic mul;
    logic div_start;
    logic acc;
    logic tgt;
    logic pick_set;
    logic k_clear;
    logic k_inc;
  } cmd_t;

  typedef struct packed {
    logic range_err;
    logic op;
    logic k_last;
    logic div_done;
    logic hit;
    logic clr_last;
  } sts_t;

endpackage

>>> rtl/lda_gibbs_topic_resampler.sv
// ---------------------------------------------------------------------------
// LDA Gibbs topic resampler
// Collapsed Gibbs count tables with per-token topic add and resample.
//
//   channel   handshake             payload
//   item      start / busy          item   (item_t)
//   result    done strobe           result (result_t)
//   config    APB write/read        pwdata / prdata
//
// Add item: the current topic's counts are read, incremented and written back, then done strobes.
// Resample item: the current topic's counts are decremented, a weight is formed for each of the K
// topics in use by the iterative divider, one quotient bit per cycle, then S topics (1..K) are
// searched and the picked topic's counts are incremented. Out-of-range item: strobe in the
// next cycle. busy drops in the cycle after each strobe. After reset a clearing pass zeroes
// the count memories; busy stays high through it. Results cannot be stalled.
// ---------------------------------------------------------------------------
module lda_gibbs_topic_resampler import lgtr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  item_t       item,
  output logic        done,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]     alpha_q12;
  logic [15:0]     beta_q12;
  logic [KN_W-1:0] topics_in_use;
  logic [VN_W-1:0] vocab_in_use;
  cfg_t            cfg;
  cmd_t            cmd;
  sts_t            sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_q12     <= 16'd2048;
      beta_q12      <= 16'd410;
      topics_in_use <= KN_W'(MAX_TOPICS);
      vocab_in_use  <= VN_W'(MAX_VOCAB);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_ALPHA: alpha_q12     <= pwdata[15:0];
        REG_BETA:  beta_q12      <= pwdata[15:0];
        REG_TOPIC: topics_in_use <= pwdata[KN_W-1:0];
        REG_VOCAB: vocab_in_use  <= pwdata[VN_W-1:0];
        default:   alpha_q12     <= alpha_q12;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ALPHA: prdata = 32'(alpha_q12);
      REG_BETA:  prdata = 32'(beta_q12);
      REG_TOPIC: prdata = 32'(topics_in_use);
      REG_VOCAB: prdata = 32'(vocab_in_use);
      default:   prdata = '0;
    endcase
  end

  always_comb begin
    cfg.alpha = alpha_q12;
    cfg.beta  = beta_q12;
    if (topics_in_use == '0) cfg.topics = KN_W'(1);
    else if (topics_in_use > KN_W'(MAX_TOPICS)) cfg.topics = KN_W'(MAX_TOPICS);
    else cfg.topics = topics_in_use;
    if (vocab_in_use == '0) cfg.vocab = VN_W'(1);
    else if (vocab_in_use > VN_W'(MAX_VOCAB)) cfg.vocab = VN_W'(MAX_VOCAB);
    else cfg.vocab = vocab_in_use;
  end

  lgtr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  lgtr_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item),
    .cmd    (cmd),
    .sts    (sts),
    .result (result)
  );

endmodule

>>> rtl/lgtr_div.sv
// ---------------------------------------------------------------------------
// LDA Gibbs weight divider
// Restoring divider, one quotient bit per cycle, saturated to the weight width.
// ---------------------------------------------------------------------------
module lgtr_div import lgtr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [PROD_W-1:0]   num,
  input  logic [DEN_W-1:0]    den,
  output logic                done,
  output logic [WEIGHT_W-1:0] quo
);

  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den_r;
  logic [PROD_W-1:0] numsh;
  logic [PROD_W-1:0] q;
  logic [DIV_CW-1:0] cnt;
  logic              run;
  logic [DEN_W:0]    r2;
  logic [DEN_W:0]    diff;
  logic              ge;

  assign r2   = {rem, numsh[PROD_W-1]};
  assign ge   = r2 >= {1'b0, den_r};
  assign diff = r2 - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      run  <= 1'b1;
      done <= 1'b0;
      cnt  <= DIV_CW'(PROD_W - 1);
    end else if (run) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      den_r <= den;
      numsh <= num;
      q     <= '0;
    end else if (run) begin
      rem   <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
      numsh <= {numsh[PROD_W-2:0], 1'b0};
      q     <= {q[PROD_W-2:0], ge};
    end
  end

  always_comb begin
    if (den_r == '0) quo = '0;
    else if (|q[PROD_W-1:WEIGHT_W]) quo = '1;
    else quo = q[WEIGHT_W-1:0];
  end

endmodule

>>> rtl/lgtr_dp.sv
// ---------------------------------------------------------------------------
// LDA Gibbs datapath
// Count memories, weight arithmetic, running sum and cumulative search.
// ---------------------------------------------------------------------------
module lgtr_dp import lgtr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  item_t   item,
  input  cmd_t    cmd,
  output sts_t    sts,
  output result_t result
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;

  logic [COUNT_WIDTH-1:0] doc_mem  [2**DOC_AW];
  logic [COUNT_WIDTH-1:0] word_mem [2**WORD_AW];
  logic [TOTAL_WIDTH-1:0] tot_mem  [MAX_TOPICS];
  logic [WEIGHT_W-1:0]    cum_mem  [MAX_TOPICS];

  item_t                  item_r;
  logic                   err;
  logic                   flag;
  logic [TOPIC_W-1:0]     pick;
  logic [TOPIC_W-1:0]     k;
  logic [WEIGHT_W-1:0]    total;
  logic [WEIGHT_W-1:0]    target;
  logic [PROD_W-1:0]      prod;
  logic [DEN_W-1:0]       den;
  logic [BV_W-1:0]        bv;
  logic [WORD_AW-1:0]     clr_cnt;
  logic [COUNT_WIDTH-1:0] doc_q, word_q;
  logic [TOTAL_WIDTH-1:0] tot_q;
  logic [WEIGHT_W-1:0]    cum_q;

  logic [TOPIC_W-1:0]     sel_topic;
  logic [DOC_AW-1:0]      doc_addr;
  logic [WORD_AW-1:0]     word_addr;
  logic [TOPIC_W-1:0]     tot_addr;
  logic [COUNT_WIDTH-1:0] doc_new, word_new;
  logic [TOTAL_WIDTH-1:0] tot_new;
  logic                   upd_flag;
  logic [OPER_W-1:0]      a_val, b_val;
  logic [WEIGHT_W:0]      sum;
  logic [WEIGHT_W-1:0]    total_next;
  logic [WEIGHT_W+15:0]   tprod;
  logic                   div_done;
  logic [WEIGHT_W-1:0]    weight;

  always_comb begin
    case (cmd.sel)
      SEL_CUR:  sel_topic = item_r.current_topic;
      SEL_K:    sel_topic = k;
      default:  sel_topic = pick;
    endcase
  end

  assign doc_addr  = cmd.clr ? clr_cnt[DOC_AW-1:0] : {item_r.doc_index, sel_topic};
  assign word_addr = cmd.clr ? clr_cnt : {item_r.word_id, sel_topic};
  assign tot_addr  = cmd.clr ? clr_cnt[TOPIC_W-1:0] : sel_topic;

  always_comb begin
    upd_flag = 1'b0;
    if (cmd.upd_add) begin
      doc_new  = (doc_q == COUNT_MAX) ? doc_q : doc_q + 1'b1;
      word_new = (word_q == COUNT_MAX) ? word_q : word_q + 1'b1;
      tot_new  = (tot_q == TOTAL_MAX) ? tot_q : tot_q + 1'b1;
      upd_flag = (doc_q == COUNT_MAX) || (word_q == COUNT_MAX) || (tot_q == TOTAL_MAX);
    end else begin
      doc_new  = (doc_q == '0) ? doc_q : doc_q - 1'b1;
      word_new = (word_q == '0) ? word_q : word_q - 1'b1;
      tot_new  = (tot_q == '0) ? tot_q : tot_q - 1'b1;
      upd_flag = (doc_q == '0) || (word_q == '0) || (tot_q == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr || cmd.upd) doc_mem[doc_addr] <= cmd.clr ? '0 : doc_new;
    doc_q <= doc_mem[doc_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr || cmd.upd) word_mem[word_addr] <= cmd.clr ? '0 : word_new;
    word_q <= word_mem[word_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr || cmd.upd) tot_mem[tot_addr] <= cmd.clr ? '0 : tot_new;
    tot_q <= tot_mem[tot_addr];
  end

  assign sum        = {1'b0, total} + {1'b0, weight};
  assign total_next = sum[WEIGHT_W] ? '1 : sum[WEIGHT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.acc) cum_mem[k] <= total_next;
    cum_q <= cum_mem[k];
  end

  assign a_val = {1'b0, doc_q, 12'b0} + OPER_W'(cfg.alpha);
  assign b_val = {1'b0, word_q, 12'b0} + OPER_W'(cfg.beta);
  assign tprod = total * item_r.random_fraction;

  lgtr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (prod),
    .den   (den),
    .done  (div_done),
    .quo   (weight)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      k       <= '0;
    end else begin
      if (cmd.clr) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.k_clear) k <= '0;
      else if (cmd.k_inc) k <= k + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= item;
      err    <= sts.range_err;
      flag   <= 1'b0;
      pick   <= item.current_topic;
      total  <= '0;
      bv     <= BV_W'(cfg.beta) * BV_W'(cfg.vocab);
    end else begin
      if (cmd.upd) flag <= flag | upd_flag;
      if (cmd.acc) total <= total_next;
      if (cmd.tgt) begin
        target <= tprod[WEIGHT_W+15:16];
        pick   <= '0;
      end else if (cmd.pick_set) begin
        pick <= k;
      end
    end
    if (cmd.mul) begin
      prod <= a_val * b_val;
      den  <= DEN_W'({tot_q, 12'b0}) + DEN_W'(bv);
    end
  end

  always_comb begin
    sts.range_err = (32'(item.doc_index) >= MAX_DOCS) ||
                    ({1'b0, item.word_id} >= cfg.vocab) ||
                    ({1'b0, item.current_topic} >= cfg.topics);
    sts.op        = item_r.opcode;
    sts.k_last    = (KN_W'(k) + 1'b1) == cfg.topics;
    sts.div_done  = div_done;
    sts.hit       = target < cum_q;
    sts.clr_last  = &clr_cnt;
  end

  assign result.new_topic = pick;
  assign result.status    = err ? ST_RANGE : (flag ? ST_COUNT : ST_OK);

endmodule

>>> rtl/lgtr_ctrl.sv
// ---------------------------------------------------------------------------
// LDA Gibbs controller
// Sequences clearing, count updates, the weight pass, the search and writeback.
// ---------------------------------------------------------------------------
module lgtr_ctrl import lgtr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic done
);

  `include "lda_gibbs_topic_resampler_assert.svh"

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.sel    = SEL_CUR;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = sts.range_err ? S_EMIT : S_ORD;
        end
      end
      S_ORD: state_next = S_OUPD;
      S_OUPD: begin
        cmd.upd     = 1'b1;
        cmd.upd_add = !sts.op;
        cmd.k_clear = 1'b1;
        state_next  = sts.op ? S_KRD : S_EMIT;
      end
      S_KRD: begin
        cmd.sel    = SEL_K;
        state_next = S_KMUL;
      end
      S_KMUL: begin
        cmd.sel    = SEL_K;
        cmd.mul    = 1'b1;
        state_next = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_DWAIT;
      end
      S_DWAIT: if (sts.div_done) state_next = S_ACC;
      S_ACC: begin
        cmd.acc = 1'b1;
        if (sts.k_last) state_next = S_TGT;
        else begin
          cmd.k_inc  = 1'b1;
          state_next = S_KRD;
        end
      end
      S_TGT: begin
        cmd.tgt     = 1'b1;
        cmd.k_clear = 1'b1;
        state_next  = S_SRD;
      end
      S_SRD: state_next = S_SCMP;
      S_SCMP: begin
        if (sts.hit) begin
          cmd.pick_set = 1'b1;
          state_next   = S_ARD;
        end else if (sts.k_last) begin
          state_next = S_ARD;
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = S_SRD;
        end
      end
      S_ARD: begin
        cmd.sel    = SEL_PICK;
        state_next = S_AUPD;
      end
      S_AUPD: begin
        cmd.sel     = SEL_PICK;
        cmd.upd     = 1'b1;
        cmd.upd_add = 1'b1;
        state_next  = S_EMIT;
      end
      S_EMIT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = state != S_IDLE;
  assign done = state == S_EMIT;

  `LGTR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `LGTR_ASSERT_NEXT(a_emit_idle, done, state == S_IDLE, "result not followed by idle")
  `LGTR_ASSERT_NOW(a_acc_div, state == S_ACC, sts.div_done, "accumulate without quotient")

endmodule
